// File: sv/mcr_pkg.sv
// shared types and constants of the multitouch contact reporter
`default_nettype none

package mcr_pkg;

  localparam int COORD_W    = 12;
  localparam int SLOT_W     = 4;
  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [BYTE_W-1:0]  EMPTY_MARK  = 8'hFF;
  localparam logic [BYTE_W-1:0]  STATUS_DOWN = 8'd1;
  localparam logic [BYTE_W-1:0]  STATUS_MOVE = 8'd2;
  localparam logic [SLOT_W-1:0]  SYNC_SLOT   = 4'hF;
  localparam logic [COORD_W-1:0] COORD_MAX   = 12'hFFF;

  localparam logic EV_CONTACT = 1'b0;
  localparam logic EV_RELEASE = 1'b1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SWAP_XY   = 3'd0,
    CFG_REVERSE_X = 3'd1,
    CFG_REVERSE_Y = 3'd2,
    CFG_X_MAX     = 3'd3,
    CFG_Y_MAX     = 3'd4
  } mcr_cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_REL
  } mcr_state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic load_contact;
    logic load_sync;
    logic load_release;
    logic frame_end;
  } mcr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit;
    logic last;
    logic gone_any;
    logic reported;
    logic out_free;
    logic rel_last;
  } mcr_status_t;

endpackage

`default_nettype wire

// File: sv/multitouch_contact_reporter.sv
// Multitouch contact reporter: an accepted record is captured and evaluated, and any
// result is loaded into the output register once it is free. The block takes no new
// record until it is done; a frame-end record adds one release per released slot.
// The controller emits at most one result per cycle into a single output register, so
// a stalled result channel holds the block. Reset (synchronous, active low) clears
// the frame masks and sets config registers to no swap, no reversal and 4095 limits.
`default_nettype none

module multitouch_contact_reporter #(
  parameter int POINT_SLOTS = 10
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_we,
  input  wire  [mcr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [mcr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire  [mcr_pkg::BYTE_W-1:0]       in_finger_id,
  input  wire  [mcr_pkg::BYTE_W-1:0]       in_contact_status,
  input  wire  [mcr_pkg::BYTE_W-1:0]       in_x_high,
  input  wire  [mcr_pkg::BYTE_W-1:0]       in_x_low,
  input  wire  [mcr_pkg::BYTE_W-1:0]       in_y_high,
  input  wire  [mcr_pkg::BYTE_W-1:0]       in_y_low,
  input  wire                              in_frame_last,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic                             out_event_kind,
  output logic [mcr_pkg::SLOT_W-1:0]       out_slot,
  output logic [mcr_pkg::COORD_W-1:0]      out_pos_x,
  output logic [mcr_pkg::COORD_W-1:0]      out_pos_y,
  output logic                             out_frame_sync,
  output logic                             out_end_of_run
);
  import mcr_pkg::*;

  mcr_cmd_t    cmd;
  mcr_status_t status;

  // sequencer
  mcr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath
  mcr_dp #(
    .POINT_SLOTS (POINT_SLOTS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_finger_id      (in_finger_id),
    .in_contact_status (in_contact_status),
    .in_x_high         (in_x_high),
    .in_x_low          (in_x_low),
    .in_y_high         (in_y_high),
    .in_y_low          (in_y_low),
    .in_frame_last     (in_frame_last),
    .cmd               (cmd),
    .status            (status),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_event_kind    (out_event_kind),
    .out_slot          (out_slot),
    .out_pos_x         (out_pos_x),
    .out_pos_y         (out_pos_y),
    .out_frame_sync    (out_frame_sync),
    .out_end_of_run    (out_end_of_run)
  );

endmodule

`default_nettype wire

// File: sv/mcr_ctrl.sv
// controller state machine of the multitouch contact reporter
`default_nettype none

module mcr_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  mcr_pkg::mcr_status_t status,
  output mcr_pkg::mcr_cmd_t    cmd
);
  import mcr_pkg::*;

  mcr_state_t state_r;
  mcr_state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (status.out_free) begin
          if (status.last && status.gone_any) begin
            state_nxt = ST_REL;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_REL: begin
        if (status.out_free && status.rel_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready         = 1'b0;
    cmd              = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_EVAL: begin
        if (status.out_free) begin
          cmd.load_contact = status.hit;
          cmd.load_sync    = !status.hit && status.last && !status.gone_any &&
                             status.reported;
          cmd.frame_end    = status.last;
        end
      end
      ST_REL: begin
        cmd.load_release = status.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: sv/mcr_dp.sv
// datapath: config, frame masks, position math, release scan, output register
`default_nettype none

module mcr_dp #(
  parameter int POINT_SLOTS = 10
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   cfg_we,
  input  wire  [mcr_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire  [mcr_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  wire  [mcr_pkg::BYTE_W-1:0]            in_finger_id,
  input  wire  [mcr_pkg::BYTE_W-1:0]            in_contact_status,
  input  wire  [mcr_pkg::BYTE_W-1:0]            in_x_high,
  input  wire  [mcr_pkg::BYTE_W-1:0]            in_x_low,
  input  wire  [mcr_pkg::BYTE_W-1:0]            in_y_high,
  input  wire  [mcr_pkg::BYTE_W-1:0]            in_y_low,
  input  wire                                   in_frame_last,
  input  mcr_pkg::mcr_cmd_t                     cmd,
  output mcr_pkg::mcr_status_t                  status,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output logic                                  out_event_kind,
  output logic [mcr_pkg::SLOT_W-1:0]            out_slot,
  output logic [mcr_pkg::COORD_W-1:0]           out_pos_x,
  output logic [mcr_pkg::COORD_W-1:0]           out_pos_y,
  output logic                                  out_frame_sync,
  output logic                                  out_end_of_run
);
  import mcr_pkg::*;

  function automatic logic [COORD_W-1:0] mirror(input logic [COORD_W-1:0] limit,
                                                input logic [COORD_W-1:0] v);
    mirror = (v > limit) ? '0 : (limit - v);
  endfunction

  // configuration registers
  logic               swap_xy_r;
  logic               reverse_x_r;
  logic               reverse_y_r;
  logic [COORD_W-1:0] x_max_r;
  logic [COORD_W-1:0] y_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swap_xy_r   <= 1'b0;
      reverse_x_r <= 1'b0;
      reverse_y_r <= 1'b0;
      x_max_r     <= COORD_MAX;
      y_max_r     <= COORD_MAX;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SWAP_XY:   swap_xy_r   <= cfg_wdata[0];
        CFG_REVERSE_X: reverse_x_r <= cfg_wdata[0];
        CFG_REVERSE_Y: reverse_y_r <= cfg_wdata[0];
        CFG_X_MAX:     x_max_r     <= cfg_wdata[COORD_W-1:0];
        CFG_Y_MAX:     y_max_r     <= cfg_wdata[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // captured transaction
  logic [BYTE_W-1:0] id_r;
  logic [BYTE_W-1:0] st_r;
  logic [BYTE_W-1:0] xh_r;
  logic [3:0]        xl_r;
  logic [BYTE_W-1:0] yh_r;
  logic [3:0]        yl_r;
  logic              last_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      id_r   <= in_finger_id;
      st_r   <= in_contact_status;
      xh_r   <= in_x_high;
      xl_r   <= in_x_low[3:0];
      yh_r   <= in_y_high;
      yl_r   <= in_y_low[3:0];
      last_r <= in_frame_last;
    end
  end

  // record decode and position
  logic                   rec_ok;
  logic                   id_ok;
  logic                   hit;
  logic [SLOT_W-1:0]      item_slot;
  logic [COORD_W-1:0]     raw_x;
  logic [COORD_W-1:0]     raw_y;
  logic [COORD_W-1:0]     sw_x;
  logic [COORD_W-1:0]     sw_y;
  logic [COORD_W-1:0]     pos_x;
  logic [COORD_W-1:0]     pos_y;

  always_comb begin
    rec_ok    = (xh_r != EMPTY_MARK) && (yh_r != EMPTY_MARK) &&
                ((st_r == STATUS_DOWN) || (st_r == STATUS_MOVE));
    id_ok     = (id_r != '0) && (id_r <= BYTE_W'(POINT_SLOTS));
    hit       = rec_ok && id_ok;
    item_slot = SLOT_W'(id_r - 8'd1);
    raw_x     = {xh_r, xl_r};
    raw_y     = {yh_r, yl_r};
    sw_x      = swap_xy_r ? raw_y : raw_x;
    sw_y      = swap_xy_r ? raw_x : raw_y;
    pos_x     = reverse_x_r ? mirror(x_max_r, sw_x) : sw_x;
    pos_y     = reverse_y_r ? mirror(y_max_r, sw_y) : sw_y;
  end

  // frame masks
  logic [POINT_SLOTS-1:0] fc_r;
  logic [POINT_SLOTS-1:0] fc_nxt;
  logic [POINT_SLOTS-1:0] prev_r;
  logic [POINT_SLOTS-1:0] prev_nxt;
  logic                   reported_r;
  logic                   reported_nxt;
  logic [POINT_SLOTS-1:0] gone_r;
  logic [POINT_SLOTS-1:0] gone_nxt;
  logic [POINT_SLOTS-1:0] hit_oh;
  logic [POINT_SLOTS-1:0] new_fc;
  logic [POINT_SLOTS-1:0] gone;
  logic [POINT_SLOTS-1:0] gone_rest;
  logic [SLOT_W-1:0]      rel_slot;

  always_comb begin
    hit_oh    = hit ? (POINT_SLOTS'(1) << item_slot) : '0;
    new_fc    = fc_r | hit_oh;
    gone      = prev_r & ~new_fc;
    gone_rest = gone_r & (gone_r - POINT_SLOTS'(1));
  end

  // lowest pending release slot
  always_comb begin
    rel_slot = '0;
    for (int i = POINT_SLOTS - 1; i >= 0; i--) begin
      if (gone_r[i]) begin
        rel_slot = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    fc_nxt       = fc_r;
    prev_nxt     = prev_r;
    reported_nxt = reported_r;
    gone_nxt     = gone_r;
    if (cmd.load_contact) begin
      fc_nxt       = new_fc;
      reported_nxt = 1'b1;
    end
    if (cmd.frame_end) begin
      prev_nxt     = new_fc;
      fc_nxt       = '0;
      reported_nxt = 1'b0;
      gone_nxt     = gone;
    end
    if (cmd.load_release) begin
      gone_nxt = gone_rest;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r       <= '0;
      prev_r     <= '0;
      reported_r <= 1'b0;
      gone_r     <= '0;
    end else begin
      fc_r       <= fc_nxt;
      prev_r     <= prev_nxt;
      reported_r <= reported_nxt;
      gone_r     <= gone_nxt;
    end
  end

  // output register
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic               out_free;
  logic               load;
  logic               ev_kind_nxt;
  logic [SLOT_W-1:0]  ev_slot_nxt;
  logic [COORD_W-1:0] ev_x_nxt;
  logic [COORD_W-1:0] ev_y_nxt;
  logic               ev_sync_nxt;
  logic               ev_eor_nxt;
  logic               ev_kind_r;
  logic [SLOT_W-1:0]  ev_slot_r;
  logic [COORD_W-1:0] ev_x_r;
  logic [COORD_W-1:0] ev_y_r;
  logic               ev_sync_r;
  logic               ev_eor_r;

  always_comb begin
    out_free = !out_valid_r || out_ready;
    load     = cmd.load_contact || cmd.load_sync || cmd.load_release;
    out_valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
    ev_kind_nxt = EV_RELEASE;
    ev_slot_nxt = SYNC_SLOT;
    ev_x_nxt    = '0;
    ev_y_nxt    = '0;
    ev_sync_nxt = 1'b1;
    ev_eor_nxt  = 1'b1;
    if (cmd.load_contact) begin
      ev_kind_nxt = EV_CONTACT;
      ev_slot_nxt = item_slot;
      ev_x_nxt    = pos_x;
      ev_y_nxt    = pos_y;
      ev_sync_nxt = last_r && (gone == '0);
      ev_eor_nxt  = !last_r || (gone == '0);
    end else if (cmd.load_release) begin
      ev_slot_nxt = rel_slot;
      ev_sync_nxt = (gone_rest == '0);
      ev_eor_nxt  = (gone_rest == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ev_kind_r <= ev_kind_nxt;
      ev_slot_r <= ev_slot_nxt;
      ev_x_r    <= ev_x_nxt;
      ev_y_r    <= ev_y_nxt;
      ev_sync_r <= ev_sync_nxt;
      ev_eor_r  <= ev_eor_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_kind = ev_kind_r;
  assign out_slot       = ev_slot_r;
  assign out_pos_x      = ev_x_r;
  assign out_pos_y      = ev_y_r;
  assign out_frame_sync = ev_sync_r;
  assign out_end_of_run = ev_eor_r;

  // status to controller
  always_comb begin
    status.hit      = hit;
    status.last     = last_r;
    status.gone_any = (gone != '0);
    status.reported = reported_r;
    status.out_free = out_free;
    status.rel_last = (gone_rest == '0);
  end

`ifndef SYNTH
  // a result is loaded only into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> out_free)
    else $error("result loaded into a busy output register");

  // one result source per cycle
  a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load_contact, cmd.load_sync, cmd.load_release}))
    else $error("more than one result source in a cycle");

  // a release is only issued for a pending slot
  a_rel_pending: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_release |-> (gone_r != '0))
    else $error("release issued with no slot pending");

  // frame end leaves an empty frame behind
  a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.frame_end |=> (fc_r == '0) && !reported_r)
    else $error("frame state not cleared at frame end");
`endif

endmodule

`default_nettype wire
